FILE: hw/rtl/lbpg_pkg.sv
package lbpg_pkg;

    localparam int MAX_FLASHES = 15;
    localparam int FLASH_W     = $clog2(MAX_FLASHES + 1);
    localparam int OFF_W       = 32 + FLASH_W + 1;
    localparam int SPAN_W      = OFF_W + 1;

    localparam logic [31:0] SLOW_HALF_RST = 32'd1200000;
    localparam logic [31:0] FAST_HALF_RST = 32'd60000;
    localparam logic [31:0] STEP_RST      = 32'd120000;
    localparam logic [31:0] GAP_RST       = 32'd1500000;
    localparam logic [31:0] OFF_REFRESH   = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_ON     = 2'd1,
        ACT_OFF    = 2'd2,
        ACT_TOGGLE = 2'd3
    } lbpg_act_t;

    typedef enum logic [1:0] {
        REG_SLOW_HALF = 2'd0,
        REG_FAST_HALF = 2'd1,
        REG_FLASH_STEP = 2'd2,
        REG_FLASH_GAP = 2'd3
    } lbpg_reg_idx_t;

    typedef struct packed {
        logic [31:0] slow_half_period;
        logic [31:0] fast_half_period;
        logic [31:0] flash_step_time;
        logic [31:0] flash_gap_time;
    } lbpg_cfg_t;

    typedef struct packed {
        logic [31:0]       on_t;
        logic [SPAN_W-1:0] off_t;
        logic [SPAN_W-1:0] per_t;
    } lbpg_span_t;

endpackage

FILE: hw/rtl/lbpg_span.sv
module lbpg_span
    import lbpg_pkg::*;
(
    input  logic signed [4:0] mode,
    input  lbpg_cfg_t         cfg,
    output lbpg_span_t        span
);

    logic [FLASH_W-1:0] n_cnt;
    logic [OFF_W-1:0]   flash_off;
    logic [31:0]        half;

    always_comb begin
        if (32'(mode[3:0]) > 32'(MAX_FLASHES)) begin
            n_cnt = FLASH_W'(MAX_FLASHES);
        end else begin
            n_cnt = FLASH_W'(mode[3:0]);
        end
        flash_off = cfg.flash_step_time * {n_cnt, 1'b0};
        half      = mode[0] ? cfg.slow_half_period : cfg.fast_half_period;
    end

    always_comb begin
        priority if (mode < -5'sd1) begin
            span.on_t  = '0;
            span.off_t = '0;
            span.per_t = SPAN_W'(OFF_REFRESH);
        end else if (mode < 5'sd0) begin
            span.on_t  = '0;
            span.off_t = '0;
            span.per_t = '0;
        end else if (mode < 5'sd2) begin
            span.on_t  = half;
            span.off_t = SPAN_W'(half);
            span.per_t = SPAN_W'({half, 1'b0});
        end else begin
            span.on_t  = cfg.flash_step_time;
            span.off_t = SPAN_W'(flash_off);
            span.per_t = SPAN_W'(flash_off) + SPAN_W'(cfg.flash_gap_time);
        end
    end

endmodule

FILE: hw/rtl/led_blink_pattern_generator.sv
// LED blink pattern generator. Each input beat is one tick carrying the current time in
// microseconds and the requested mode (-2 and below off, -1 steady on, 0 fast blink,
// 1 slow blink, n >= 2 n flashes then a pause); each tick yields exactly one output beat
// with the LED command (none, on, off, toggle). A change of mode restarts the period at the
// tick's time. Throughput is one tick per clock while m_tready keeps the output moving: the
// mode's on, off and period spans are worked out as the beat enters the input register, and
// the 64-bit time compares and the state update happen between that register and the output
// register. Timing registers may be written only while no tick is in flight.
module led_blink_pattern_generator
    import lbpg_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [63:0] now_us, [68:64] mode, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [1:0] led_action, rest zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    lbpg_cfg_t cfg_reg, cfg_next;

    logic              st_valid_reg;
    logic [63:0]       st_now_reg;
    logic signed [4:0] st_mode_reg;
    lbpg_span_t        st_span_reg;
    lbpg_span_t        in_span;

    logic signed [4:0] cur_mode_reg, cur_mode_next;
    logic [63:0]       period_start_reg, period_start_next;
    logic [63:0]       last_toggle_reg, last_toggle_next;

    logic              m_valid_reg;
    lbpg_act_t         act_reg, act_next;

    logic              out_adv;
    logic              in_acc;
    logic [63:0]       base_p;
    logic [63:0]       base_t;

    function automatic logic past(input logic [63:0] now, input logic [63:0] base,
                                  input logic [SPAN_W-1:0] span);
        logic [63:0] diff;
        diff = now - base;
        return (now > base) && (diff > 64'(span));
    endfunction

    assign cfg_ready = 1'b1;
    assign out_adv   = !m_valid_reg || m_tready;
    assign s_tready  = !st_valid_reg || out_adv;
    assign in_acc    = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {6'b0, act_reg};

    lbpg_span u_span (
        .mode (s_tdata[68:64]),
        .cfg  (cfg_reg),
        .span (in_span)
    );

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (lbpg_reg_idx_t'(cfg_index))
                REG_SLOW_HALF:  cfg_next.slow_half_period = cfg_data;
                REG_FAST_HALF:  cfg_next.fast_half_period = cfg_data;
                REG_FLASH_STEP: cfg_next.flash_step_time  = cfg_data;
                REG_FLASH_GAP:  cfg_next.flash_gap_time   = cfg_data;
            endcase
        end
    end

    always_comb begin
        cur_mode_next = st_mode_reg;
        base_p        = (st_mode_reg != cur_mode_reg) ? st_now_reg : period_start_reg;
        base_t        = (st_mode_reg != cur_mode_reg) ? st_now_reg : last_toggle_reg;
        period_start_next = base_p;
        last_toggle_next  = base_t;
        act_next          = ACT_NONE;
        priority if (past(st_now_reg, base_p, st_span_reg.per_t)) begin
            act_next          = ACT_ON;
            period_start_next = st_now_reg;
            last_toggle_next  = st_now_reg;
        end else if (past(st_now_reg, base_p, st_span_reg.off_t)) begin
            act_next = ACT_OFF;
        end else if (past(st_now_reg, base_t, SPAN_W'(st_span_reg.on_t))) begin
            act_next         = ACT_TOGGLE;
            last_toggle_next = st_now_reg;
        end else begin
            act_next = ACT_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.slow_half_period <= SLOW_HALF_RST;
            cfg_reg.fast_half_period <= FAST_HALF_RST;
            cfg_reg.flash_step_time  <= STEP_RST;
            cfg_reg.flash_gap_time   <= GAP_RST;
            st_valid_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
            cur_mode_reg     <= '0;
            period_start_reg <= '0;
            last_toggle_reg  <= '0;
        end else begin
            cfg_reg <= cfg_next;
            if (s_tready) begin
                st_valid_reg <= s_tvalid;
            end
            if (out_adv) begin
                m_valid_reg <= st_valid_reg;
            end
            if (out_adv && st_valid_reg) begin
                cur_mode_reg     <= cur_mode_next;
                period_start_reg <= period_start_next;
                last_toggle_reg  <= last_toggle_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            st_now_reg  <= s_tdata[63:0];
            st_mode_reg <= s_tdata[68:64];
            st_span_reg <= in_span;
        end
        if (out_adv && st_valid_reg) begin
            act_reg <= act_next;
        end
    end

endmodule

FILE: hw/rtl/lbpg_checker.sv
module lbpg_checker
    import lbpg_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_rst_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // an empty output stage never back-pressures the input
    a_no_stall: assert property (@(posedge aclk)
        !m_tvalid |-> s_tready)
        else $error("input stalled with output stage empty");

    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[7:2] == 6'b0)
        else $error("result padding not zero");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("register write not taken");

endmodule

bind led_blink_pattern_generator lbpg_checker u_lbpg_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);

FILE: tb/led_blink_pattern_generator_tb.sv
`timescale 1ns / 1ps

module led_blink_pattern_generator_tb;
    import lbpg_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_TICKS  = 160;
    localparam int HOLD_CYCLES  = 300;

    localparam logic signed [4:0] MODE_OFF_MIN   = -16;
    localparam logic signed [4:0] MODE_OFF       = -2;
    localparam logic signed [4:0] MODE_ON        = -1;
    localparam logic signed [4:0] MODE_FAST      = 0;
    localparam logic signed [4:0] MODE_SLOW      = 1;
    localparam logic signed [4:0] MODE_FLASH_MAX = 15;

    typedef struct packed {
        logic [63:0]       now;
        logic signed [4:0] mode;
        logic              typed;
        lbpg_act_t         act;
    } tick_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [71:0] s_tdata = '0;   // [63:0] now_us, [68:64] mode, rest zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // [1:0] led_action, rest zero
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // timing registers and blink state as the block should hold them
    logic [31:0]       slow_half = SLOW_HALF_RST;
    logic [31:0]       fast_half = FAST_HALF_RST;
    logic [31:0]       flash_step = STEP_RST;
    logic [31:0]       flash_gap = GAP_RST;
    logic signed [4:0] led_mode = '0;
    logic [63:0]       period_start = '0;
    logic [63:0]       last_toggle = '0;

    lbpg_act_t led_expect_q[$];
    lbpg_act_t led_want;
    int        mismatches = 0;
    int        stall_cycles = 0;
    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    bit        hold_req = 1'b0;
    bit        hold_seen = 1'b0;
    int        hold_left = 0;

    // default timing after reset
    tick_row_t directed_ticks [24] = '{
        '{64'd0,            MODE_FAST,      1'b1, ACT_NONE},
        '{64'd60001,        MODE_FAST,      1'b1, ACT_OFF},
        '{64'd120001,       MODE_FAST,      1'b1, ACT_ON},
        '{64'd120001,       MODE_FAST,      1'b1, ACT_NONE},
        '{64'd180002,       MODE_SLOW,      1'b1, ACT_NONE},
        '{64'd1380003,      MODE_SLOW,      1'b1, ACT_OFF},
        '{64'd200,          MODE_SLOW,      1'b1, ACT_NONE},
        '{64'd10000000,     MODE_ON,        1'b1, ACT_NONE},
        '{64'd10000001,     MODE_ON,        1'b1, ACT_ON},
        '{64'd20000000,     MODE_OFF,       1'b1, ACT_NONE},
        '{64'd20000001,     MODE_OFF,       1'b1, ACT_OFF},
        '{64'd4314967296,   MODE_OFF,       1'b1, ACT_ON},
        '{64'd30000000,     MODE_OFF_MIN,   1'b1, ACT_NONE},
        '{64'd30000001,     MODE_OFF_MIN,   1'b1, ACT_OFF},
        '{64'd40000000,     5'sd2,          1'b1, ACT_NONE},
        '{64'd40120001,     5'sd2,          1'b1, ACT_TOGGLE},
        '{64'd40240002,     5'sd2,          1'b0, ACT_NONE},
        '{64'd40480001,     5'sd2,          1'b1, ACT_OFF},
        '{64'd50000000,     MODE_FLASH_MAX, 1'b1, ACT_NONE},
        '{64'd53600001,     MODE_FLASH_MAX, 1'b1, ACT_OFF},
        '{64'd55100001,     MODE_FLASH_MAX, 1'b1, ACT_ON},
        '{64'hFFFF_FFFF_FFFF_FFF0, 5'sd7,   1'b1, ACT_NONE},
        '{64'hFFFF_FFFF_FFFF_FFFF, 5'sd7,   1'b1, ACT_NONE},
        '{64'h8000_0000_0000_0000, MODE_FAST, 1'b1, ACT_NONE}
    };

    led_blink_pattern_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    function automatic void mode_spans(input logic signed [4:0] m, output logic [63:0] on_t,
                                       output logic [63:0] off_t, output logic [63:0] per_t);
        int n;
        n = m;
        if (m < MODE_ON) begin
            on_t = '0;
            off_t = '0;
            per_t = 64'(OFF_REFRESH);
        end else if (m == MODE_ON) begin
            on_t = '0;
            off_t = '0;
            per_t = '0;
        end else if (m <= MODE_SLOW) begin
            on_t = (m == MODE_SLOW) ? 64'(slow_half) : 64'(fast_half);
            off_t = on_t;
            per_t = on_t << 1;
        end else begin
            if (n > MAX_FLASHES) n = MAX_FLASHES;
            on_t = 64'(flash_step);
            off_t = on_t * 64'(2 * n);
            per_t = off_t + 64'(flash_gap);
        end
    endfunction

    // exact: now beyond base + span, no wrap
    function automatic bit elapsed(input logic [63:0] now, input logic [63:0] base,
                                   input logic [63:0] span);
        return (now > base) && ((now - base) > span);
    endfunction

    function automatic lbpg_act_t predict_led(input logic [63:0] now,
                                              input logic signed [4:0] mode);
        logic [63:0] on_t, off_t, per_t;
        lbpg_act_t act;
        if (mode != led_mode) begin
            led_mode = mode;
            period_start = now;
            last_toggle = now;
        end
        mode_spans(led_mode, on_t, off_t, per_t);
        act = ACT_NONE;
        if (elapsed(now, period_start, per_t)) begin
            act = ACT_ON;
            period_start = now;
            last_toggle = now;
        end else if (elapsed(now, period_start, off_t)) begin
            act = ACT_OFF;
        end else if (elapsed(now, last_toggle, on_t)) begin
            act = ACT_TOGGLE;
            last_toggle = now;
        end
        return act;
    endfunction

    function automatic logic [63:0] rand_upto(input logic [63:0] lim);
        if (lim <= 64'hFFFF_FFFF) return 64'($urandom_range(0, lim[31:0]));
        return {$urandom, $urandom} % (lim + 64'd1);
    endfunction

    function automatic logic signed [4:0] pick_mode();
        if ($urandom_range(0, 9) == 0) return 5'(-$urandom_range(3, 16));
        return 5'($urandom_range(0, 17) - 2);
    endfunction

    task automatic send_tick(input logic [63:0] now, input logic signed [4:0] mode,
                             input logic typed, input lbpg_act_t want);
        lbpg_act_t act;
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, mode, now};
        do @(posedge aclk); while (!s_tready);
        act = predict_led(now, mode);
        led_expect_q.push_back(typed ? want : act);
    endtask

    task automatic drain_ticks();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (led_expect_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input lbpg_reg_idx_t idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_SLOW_HALF:  slow_half = val;
            REG_FAST_HALF:  fast_half = val;
            REG_FLASH_STEP: flash_step = val;
            REG_FLASH_GAP:  flash_gap = val;
        endcase
    endtask

    task automatic set_timing(input logic [31:0] slow, input logic [31:0] fast,
                              input logic [31:0] step, input logic [31:0] gap);
        drain_ticks();
        write_reg(REG_SLOW_HALF, slow);
        write_reg(REG_FAST_HALF, fast);
        write_reg(REG_FLASH_STEP, step);
        write_reg(REG_FLASH_GAP, gap);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // mostly runs of one mode with time moving on by about a span, some mode changes and noise
    task automatic run_phase(input int count);
        logic [63:0] t, on_t, off_t, per_t, base, delta, now_v;
        logic signed [4:0] m, mode_v;
        int r;
        t = period_start + 64'($urandom_range(0, 1000));
        m = led_mode;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
                now_v = {$urandom, $urandom};
                mode_v = 5'($urandom_range(0, 31));
                if ($urandom_range(0, 1) == 1) begin
                    t = now_v;
                    m = mode_v;
                end
                send_tick(now_v, mode_v, 1'b0, ACT_NONE);
            end else begin
                if (r < 9) begin
                    m = pick_mode();
                end else begin
                    mode_spans(m, on_t, off_t, per_t);
                    base = (on_t != 0) ? on_t : ((per_t != 0) ? per_t : 64'd4);
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3: delta = rand_upto(base);
                        4, 5:       delta = base + 64'($urandom_range(0, 2)) - 64'd1;
                        6, 7:       delta = 64'($urandom_range(0, 3));
                        default:    delta = rand_upto(per_t + base);
                    endcase
                    t = t + delta;
                end
                send_tick(t, m, 1'b0, ACT_NONE);
            end
        end
    endtask

    always @(negedge aclk) begin
        if (hold_req && !hold_seen) begin
            hold_seen = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (led_expect_q.size() == 0) begin
                $display("%0t: led_action expected none, got %0d", $time, m_tdata[1:0]);
                mismatches++;
            end else begin
                led_want = led_expect_q.pop_front();
                if (m_tdata[1:0] !== led_want) begin
                    $display("%0t: led_action expected %0d, got %0d",
                             $time, led_want, m_tdata[1:0]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_ticks[i])
            send_tick(directed_ticks[i].now, directed_ticks[i].mode,
                      directed_ticks[i].typed, directed_ticks[i].act);

        send_idle_pct = 26;
        recv_idle_pct = 72;
        set_timing(32'd1, 32'd1, 32'd1, 32'd0);
        run_phase(PHASE_TICKS);
        set_timing($urandom_range(1, 16), $urandom_range(1, 16),
                   $urandom_range(1, 16), $urandom_range(0, 16));
        run_phase(PHASE_TICKS);

        send_idle_pct = 72;
        recv_idle_pct = 26;
        set_timing(SLOW_HALF_RST, FAST_HALF_RST, STEP_RST, GAP_RST);
        hold_req = 1'b1;
        run_phase(PHASE_TICKS);
        // zero durations
        set_timing(32'd0, 32'd0, 32'd0, 32'd0);
        run_phase(PHASE_TICKS);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_timing(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        run_phase(PHASE_TICKS);
        set_timing($urandom_range(1, 5000), $urandom_range(1, 5000),
                   $urandom_range(1, 500), $urandom_range(0, 5000));
        run_phase(PHASE_TICKS);

        drain_ticks();
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
